// ----- rtl/core/rsub_pkg.sv -----
// ----------------------------------------------------------------------------
// rsub_pkg
// Shared types and constants for the rectangle subtraction block.
// ----------------------------------------------------------------------------
package rsub_pkg;

   // Default coordinate width. Sizes are one bit narrower.
   localparam int COORD_BITS_DEF = 16;

   // One slot for each possible piece: left, right, top, bottom.
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_BITS = $clog2(NUM_SLOTS);
   localparam int KIND_BITS = 3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LEFT   = 3'd0,
      KIND_RIGHT  = 3'd1,
      KIND_TOP    = 3'd2,
      KIND_BOTTOM = 3'd3,
      KIND_WHOLE  = 3'd4
   } kind_type;

   // Control handed from the geometry logic to the piece buffer.
   typedef struct packed {
      logic                 whole;  // slot 0 carries A unchanged
      logic [NUM_SLOTS-1:0] mask;   // slots that hold a non-empty piece
   } piece_ctl_type;

endpackage

// ----- rtl/core/rsub_geom.sv -----
// ----------------------------------------------------------------------------
// rsub_geom
// Intersection test and piece geometry for one pair of rectangles.
// ----------------------------------------------------------------------------
module rsub_geom #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic        [COORD_BITS-2:0] a_w,
   input  logic        [COORD_BITS-2:0] a_h,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic        [COORD_BITS-2:0] b_w,
   input  logic        [COORD_BITS-2:0] b_h,
   output logic        [COORD_BITS-1:0] slot_x [rsub_pkg::NUM_SLOTS],
   output logic        [COORD_BITS-1:0] slot_y [rsub_pkg::NUM_SLOTS],
   output logic        [COORD_BITS-2:0] slot_w [rsub_pkg::NUM_SLOTS],
   output logic        [COORD_BITS-2:0] slot_h [rsub_pkg::NUM_SLOTS],
   output rsub_pkg::piece_ctl_type      ctl
);
   import rsub_pkg::*;

   // Far edges need one extra bit so the sums never overflow.
   localparam int EW = COORD_BITS + 1;

   logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e;
   logic signed [EW-1:0] ar, ab, br, bb;
   logic signed [EW-1:0] ix, iy, ixr, iyb;
   logic signed [EW-1:0] left_w, right_w, mid_w, top_h, bot_h;
   logic                 hit;
   logic                 has_left, has_right, has_top, has_bot;

   assign ax_e = {a_x[COORD_BITS-1], a_x};
   assign ay_e = {a_y[COORD_BITS-1], a_y};
   assign bx_e = {b_x[COORD_BITS-1], b_x};
   assign by_e = {b_y[COORD_BITS-1], b_y};

   assign ar = ax_e + $signed({2'b00, a_w});
   assign ab = ay_e + $signed({2'b00, a_h});
   assign br = bx_e + $signed({2'b00, b_w});
   assign bb = by_e + $signed({2'b00, b_h});

   // Empty rectangles and rectangles that only touch do not intersect.
   assign hit = (|a_w) && (|a_h) && (|b_w) && (|b_h) &&
                (ax_e < br) && (bx_e < ar) && (ay_e < bb) && (by_e < ab);

   assign ix  = (ax_e > bx_e) ? ax_e : bx_e;
   assign iy  = (ay_e > by_e) ? ay_e : by_e;
   assign ixr = (ar < br) ? ar : br;
   assign iyb = (ab < bb) ? ab : bb;

   assign has_left  = hit && (ix > ax_e);
   assign has_right = hit && (ixr < ar);
   assign has_top   = hit && (iy > ay_e);
   assign has_bot   = hit && (iyb < ab);

   assign left_w  = ix - ax_e;
   assign right_w = ar - ixr;
   assign mid_w   = ixr - ix;
   assign top_h   = iy - ay_e;
   assign bot_h   = ab - iyb;

   // Slot 0 doubles as the whole-A piece when there is no intersection.
   assign slot_x[0] = a_x;
   assign slot_y[0] = a_y;
   assign slot_w[0] = hit ? left_w[COORD_BITS-2:0] : a_w;
   assign slot_h[0] = a_h;

   assign slot_x[1] = ixr[COORD_BITS-1:0];
   assign slot_y[1] = a_y;
   assign slot_w[1] = right_w[COORD_BITS-2:0];
   assign slot_h[1] = a_h;

   assign slot_x[2] = ix[COORD_BITS-1:0];
   assign slot_y[2] = a_y;
   assign slot_w[2] = mid_w[COORD_BITS-2:0];
   assign slot_h[2] = top_h[COORD_BITS-2:0];

   assign slot_x[3] = ix[COORD_BITS-1:0];
   assign slot_y[3] = iyb[COORD_BITS-1:0];
   assign slot_w[3] = mid_w[COORD_BITS-2:0];
   assign slot_h[3] = bot_h[COORD_BITS-2:0];

   // A fully covered A leaves every flag clear, so no piece is sent.
   assign ctl.whole = !hit;
   assign ctl.mask  = hit ? {has_bot, has_top, has_right, has_left}
                          : NUM_SLOTS'(1);

endmodule

// ----- rtl/core/rsub_emit.sv -----
// ----------------------------------------------------------------------------
// rsub_emit
// Piece buffer that sends the pending pieces of one item, one per cycle.
// ----------------------------------------------------------------------------
module rsub_emit #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [COORD_BITS-1:0]         in_x [rsub_pkg::NUM_SLOTS],
   input  logic [COORD_BITS-1:0]         in_y [rsub_pkg::NUM_SLOTS],
   input  logic [COORD_BITS-2:0]         in_w [rsub_pkg::NUM_SLOTS],
   input  logic [COORD_BITS-2:0]         in_h [rsub_pkg::NUM_SLOTS],
   input  rsub_pkg::piece_ctl_type       in_ctl,
   output logic                          free,
   output logic                          out_valid,
   output logic [COORD_BITS-1:0]         out_x,
   output logic [COORD_BITS-1:0]         out_y,
   output logic [COORD_BITS-2:0]         out_w,
   output logic [COORD_BITS-2:0]         out_h,
   output rsub_pkg::kind_type            out_kind,
   output logic                          out_last
);
   import rsub_pkg::*;

   logic [COORD_BITS-1:0] x_ff [NUM_SLOTS];
   logic [COORD_BITS-1:0] y_ff [NUM_SLOTS];
   logic [COORD_BITS-2:0] w_ff [NUM_SLOTS];
   logic [COORD_BITS-2:0] h_ff [NUM_SLOTS];
   logic                  whole_ff;
   logic [NUM_SLOTS-1:0]  pend_ff, pend_in, pend_rest;
   logic [SLOT_BITS-1:0]  sel;
   logic                  found;

   // Pending mask with its lowest piece removed.
   assign pend_rest = pend_ff & (pend_ff - NUM_SLOTS'(1));

   // The buffer can take a new item once at most one piece is left.
   assign free     = (pend_rest == '0);
   assign out_valid = |pend_ff;
   assign out_last  = out_valid && free;

   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!found && pend_ff[i]) begin
            sel   = SLOT_BITS'(i);
            found = 1'b1;
         end
      end
   end

   assign out_x    = x_ff[sel];
   assign out_y    = y_ff[sel];
   assign out_w    = w_ff[sel];
   assign out_h    = h_ff[sel];
   assign out_kind = whole_ff ? KIND_WHOLE : kind_type'(KIND_BITS'(sel));

   assign pend_in = load ? in_ctl.mask : pend_rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= in_x;
         y_ff     <= in_y;
         w_ff     <= in_w;
         h_ff     <= in_h;
         whole_ff <= in_ctl.whole;
      end
   end

endmodule

// ----- rtl/core/rect_subtract_pieces.sv -----
// ----------------------------------------------------------------------------
// rect_subtract_pieces
// Rectangle difference A minus B, delivered as up to four pieces.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It is registered,
// its pieces are computed from the input register, and it is loaded into
// the piece buffer once that is free; the buffer sends the pieces one per
// cycle on the rsp_ ports, each marked by rsp_valid for a single cycle; the
// receiver cannot stall and must take every piece as it appears. The input
// register and the piece buffer lie between acceptance and the first piece.
// An item holds the piece buffer while it sends its pieces (one to four;
// a fully covered A gives none), and the one-piece-per-cycle buffer sets
// the sustained rate: items that each give a single piece flow at one per
// cycle, items with more pieces more slowly. A new item can be accepted
// while the previous one is still sending its pieces; busy rises only when
// the input register is full and the buffer still has more than one piece
// left to send.
//
// Pieces come in the order left, right, top, bottom, each only when it is
// not empty; the left and right strips span the full height of A, the top
// and bottom strips the width of the intersection. When A and B do not
// overlap (including when either has zero width or height, or they only
// share an edge), A itself is sent as one piece of kind whole. The last
// piece of every item has rsp_last_piece set. A right or bottom strip that
// starts beyond the largest coordinate carries its origin wrapped to the
// coordinate width.
// ----------------------------------------------------------------------------
module rect_subtract_pieces #(
   parameter int COORD_BITS = rsub_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic        [COORD_BITS-2:0] req_a_w,
   input  logic        [COORD_BITS-2:0] req_a_h,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic        [COORD_BITS-2:0] req_b_w,
   input  logic        [COORD_BITS-2:0] req_b_h,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_piece_x,
   output logic signed [COORD_BITS-1:0] rsp_piece_y,
   output logic        [COORD_BITS-2:0] rsp_piece_w,
   output logic        [COORD_BITS-2:0] rsp_piece_h,
   output logic [rsub_pkg::KIND_BITS-1:0] rsp_piece_kind,
   output logic                         rsp_last_piece
);
   import rsub_pkg::*;

   // Input register holding one accepted item.
   logic                         item_valid_ff, item_valid_in;
   logic signed [COORD_BITS-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic        [COORD_BITS-2:0] a_w_ff, a_h_ff, b_w_ff, b_h_ff;

   logic [COORD_BITS-1:0] slot_x [NUM_SLOTS];
   logic [COORD_BITS-1:0] slot_y [NUM_SLOTS];
   logic [COORD_BITS-2:0] slot_w [NUM_SLOTS];
   logic [COORD_BITS-2:0] slot_h [NUM_SLOTS];
   piece_ctl_type         slot_ctl;

   logic                  buf_free;
   logic                  buf_load;
   logic                  accept;
   logic [COORD_BITS-1:0] out_x, out_y;
   kind_type              out_kind;

   // The registered item moves into the piece buffer as soon as the buffer
   // is sending its final piece or is empty.
   assign buf_load = item_valid_ff && buf_free;
   assign busy     = item_valid_ff && !buf_free;
   assign accept   = start && !busy;

   assign item_valid_in = accept ? 1'b1 : (buf_load ? 1'b0 : item_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff <= req_a_x;
         a_y_ff <= req_a_y;
         a_w_ff <= req_a_w;
         a_h_ff <= req_a_h;
         b_x_ff <= req_b_x;
         b_y_ff <= req_b_y;
         b_w_ff <= req_b_w;
         b_h_ff <= req_b_h;
      end
   end

   rsub_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .a_x    (a_x_ff),
      .a_y    (a_y_ff),
      .a_w    (a_w_ff),
      .a_h    (a_h_ff),
      .b_x    (b_x_ff),
      .b_y    (b_y_ff),
      .b_w    (b_w_ff),
      .b_h    (b_h_ff),
      .slot_x (slot_x),
      .slot_y (slot_y),
      .slot_w (slot_w),
      .slot_h (slot_h),
      .ctl    (slot_ctl)
   );

   rsub_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (buf_load),
      .in_x      (slot_x),
      .in_y      (slot_y),
      .in_w      (slot_w),
      .in_h      (slot_h),
      .in_ctl    (slot_ctl),
      .free      (buf_free),
      .out_valid (rsp_valid),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_w     (rsp_piece_w),
      .out_h     (rsp_piece_h),
      .out_kind  (out_kind),
      .out_last  (rsp_last_piece)
   );

   assign rsp_piece_x    = $signed(out_x);
   assign rsp_piece_y    = $signed(out_y);
   assign rsp_piece_kind = out_kind;

`ifndef NO_ASSERTIONS
   // A piece that is not the last of its item is always followed directly
   // by another piece of the same item.
   a_pieces_contiguous : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_piece |=> rsp_valid)
      else $error("piece stream of an item broke off before its last piece");

   // A whole-A piece is always marked as the last piece of its item.
   a_whole_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_piece_kind == KIND_WHOLE) |-> rsp_last_piece)
      else $error("whole-A piece not marked as last");

   // A stalled item stays in the input register until the buffer takes it.
   a_item_held : assert property (@(posedge clock) disable iff (reset)
      busy |=> item_valid_ff)
      else $error("registered item lost while stalled");
`endif

endmodule

// ----- tb/tb_rect_subtract_pieces.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rect_subtract_pieces
// Self-checking bench for the rectangle difference block.
// ----------------------------------------------------------------------------
// A list of rectangle pairs is built up front: a directed set that hits the
// corner cases (disjoint, touching, empty, fully covered, single strips,
// strip pairs, all four strips, wrapping coordinates), then 250 random pairs,
// most of them built so that B really cuts into A. A driver hands them to the
// block with random pauses; a monitor predicts the pieces of every accepted
// item and compares each piece the block sends with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rect_subtract_pieces;

   import rsub_pkg::*;

   localparam int CB = COORD_BITS_DEF;

   // One pair of rectangles, plus how the driver should pace it.
   typedef struct {
      logic [CB-1:0] a_x, a_y, b_x, b_y;
      logic [CB-2:0] a_w, a_h, b_w, b_h;
      int            gap;      // idle cycles after this item is taken
      bit            drain;    // hold this item until all pieces are back
   } rect_job_type;

   // One predicted piece of A.
   typedef struct {
      logic [CB-1:0] x, y;
      logic [CB-2:0] w, h;
      kind_type      kind;
      logic          last;
   } piece_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CB-1:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic        [CB-2:0] req_a_w = '0, req_a_h = '0, req_b_w = '0, req_b_h = '0;
   logic                 rsp_valid;
   logic signed [CB-1:0] rsp_piece_x, rsp_piece_y;
   logic        [CB-2:0] rsp_piece_w, rsp_piece_h;
   logic [KIND_BITS-1:0] rsp_piece_kind;
   logic                 rsp_last_piece;

   rect_job_type rect_jobs[$];     // items still to be sent
   piece_type    pieces_due[$];    // pieces predicted but not yet seen

   int  items_total   = 0;
   int  items_taken   = 0;
   int  items_covered = 0;      // items whose A vanished entirely
   int  pieces_seen   = 0;
   int  kind_count[5] = '{default: 0};
   int  error_count   = 0;
   int  hold_cnt      = 0;
   bit  taken         = 1'b0;   // the last rising edge accepted an item
   bit  gap_busy      = 1'b1;   // random pauses between items in this stretch

   rect_subtract_pieces dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_a_x        (req_a_x),
      .req_a_y        (req_a_y),
      .req_a_w        (req_a_w),
      .req_a_h        (req_a_h),
      .req_b_x        (req_b_x),
      .req_b_y        (req_b_y),
      .req_b_w        (req_b_w),
      .req_b_h        (req_b_h),
      .rsp_valid      (rsp_valid),
      .rsp_piece_x    (rsp_piece_x),
      .rsp_piece_y    (rsp_piece_y),
      .rsp_piece_w    (rsp_piece_w),
      .rsp_piece_h    (rsp_piece_h),
      .rsp_piece_kind (rsp_piece_kind),
      .rsp_last_piece (rsp_last_piece)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Builds one piece; origins wrap to the coordinate width, as the block does
   // for strips that start past the largest coordinate.
   function automatic piece_type make_piece(longint x, longint y, longint w, longint h,
                                            kind_type kind);
      piece_type p;
      p.x    = x[CB-1:0];
      p.y    = y[CB-1:0];
      p.w    = w[CB-2:0];
      p.h    = h[CB-2:0];
      p.kind = kind;
      p.last = 1'b0;
      return p;
   endfunction

   // Works out the pieces of A left after removing B and queues them in the
   // order the block sends them: left, right, top, bottom.
   function automatic void subtract_rect(
      logic signed [CB-1:0] a_x, logic signed [CB-1:0] a_y,
      logic [CB-2:0] a_w, logic [CB-2:0] a_h,
      logic signed [CB-1:0] b_x, logic signed [CB-1:0] b_y,
      logic [CB-2:0] b_w, logic [CB-2:0] b_h);
      longint    ax, ay, aw, ah, bx, by, bw, bh;
      longint    a_r, a_b, b_r, b_b, ix, iy, ix_r, iy_b;
      piece_type cut[4];
      int        n;
      bit        hit;
      ax = a_x;  ay = a_y;  aw = a_w;  ah = a_h;
      bx = b_x;  by = b_y;  bw = b_w;  bh = b_h;
      // Far edges are computed wide, so they never overflow.
      a_r = ax + aw;  a_b = ay + ah;
      b_r = bx + bw;  b_b = by + bh;
      n = 0;
      // Empty rectangles never intersect, and shared edges do not count.
      hit = aw > 0 && ah > 0 && bw > 0 && bh > 0 &&
            ax < b_r && bx < a_r && ay < b_b && by < a_b;
      if (!hit) begin
         cut[0] = make_piece(ax, ay, aw, ah, KIND_WHOLE);
         n = 1;
      end else begin
         ix   = (ax > bx) ? ax : bx;
         iy   = (ay > by) ? ay : by;
         ix_r = (a_r < b_r) ? a_r : b_r;
         iy_b = (a_b < b_b) ? a_b : b_b;
         if (ix > ax) begin
            cut[n] = make_piece(ax, ay, ix - ax, ah, KIND_LEFT);
            n++;
         end
         if (ix_r < a_r) begin
            cut[n] = make_piece(ix_r, ay, a_r - ix_r, ah, KIND_RIGHT);
            n++;
         end
         if (iy > ay) begin
            cut[n] = make_piece(ix, ay, ix_r - ix, iy - ay, KIND_TOP);
            n++;
         end
         if (iy_b < a_b) begin
            cut[n] = make_piece(ix, iy_b, ix_r - ix, a_b - iy_b, KIND_BOTTOM);
            n++;
         end
      end
      // With no strip left, B swallowed A and nothing is sent.
      if (n == 0) begin
         items_covered++;
      end
      for (int i = 0; i < n; i++) begin
         cut[i].last = (i == n - 1);
         pieces_due.push_back(cut[i]);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------

   // Queues one item. Coordinates and sizes arrive as plain integers and are
   // cut down to the port widths here, so out-of-range sums simply wrap.
   // In back-to-back stretches most items follow with no pause at all.
   task automatic add_item(int ax, int ay, int aw, int ah,
                           int bx, int by, int bw, int bh, bit drain);
      rect_job_type j;
      j.a_x   = ax[CB-1:0];
      j.a_y   = ay[CB-1:0];
      j.a_w   = aw[CB-2:0];
      j.a_h   = ah[CB-2:0];
      j.b_x   = bx[CB-1:0];
      j.b_y   = by[CB-1:0];
      j.b_w   = bw[CB-2:0];
      j.b_h   = bh[CB-2:0];
      if (gap_busy || $urandom_range(0, 3) == 0) begin
         j.gap = int'($urandom_range(0, 11));
      end else begin
         j.gap = 0;
      end
      j.drain = drain;
      rect_jobs.push_back(j);
      items_total++;
   endtask

   // Sizes lean toward small values, with the full range and both extremes
   // showing up now and then.
   function automatic int rand_size();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         return $urandom_range(1, 64);
      end else if (sel < 75) begin
         return $urandom_range(1, 4095);
      end else if (sel < 95) begin
         return $urandom_range(0, 32767);
      end
      return sel[0] ? 0 : 32767;
   endfunction

   // One random item. Most are shaped so that B actually cuts A; the rest are
   // covered, touching, empty or plain noise.
   task automatic add_random_item(bit drain);
      int sel, side, ax, ay, aw, ah, bx, by, bw, bh;
      sel = $urandom_range(0, 99);
      ax  = $urandom_range(0, 65535);
      ay  = $urandom_range(0, 65535);
      aw  = rand_size();
      ah  = rand_size();
      bw  = rand_size();
      bh  = rand_size();
      bx  = ax - 10 + int'($urandom_range(0, aw + 10));
      by  = ay - 10 + int'($urandom_range(0, ah + 10));
      if (sel >= 55 && sel < 65) begin
         // B covers all of A, with a margin of zero to five on each side.
         aw = $urandom_range(1, 30000);
         ah = $urandom_range(1, 30000);
         bx = ax - int'($urandom_range(0, 5));
         by = ay - int'($urandom_range(0, 5));
         bw = aw + (ax - bx) + int'($urandom_range(0, 5));
         bh = ah + (ay - by) + int'($urandom_range(0, 5));
      end else if (sel >= 65 && sel < 75) begin
         // B sits flush against one side of A.
         side = $urandom_range(0, 3);
         case (side)
            0: bx = ax + aw;
            1: bx = ax - bw;
            2: by = ay + ah;
            default: by = ay - bh;
         endcase
      end else if (sel >= 75 && sel < 82) begin
         side = $urandom_range(0, 3);
         case (side)
            0: aw = 0;
            1: ah = 0;
            2: bw = 0;
            default: bh = 0;
         endcase
      end else if (sel >= 82) begin
         ax = $urandom_range(0, 65535);
         ay = $urandom_range(0, 65535);
         bx = $urandom_range(0, 65535);
         by = $urandom_range(0, 65535);
         aw = $urandom_range(0, 32767);
         ah = $urandom_range(0, 32767);
         bw = $urandom_range(0, 32767);
         bh = $urandom_range(0, 32767);
      end
      add_item(ax, ay, aw, ah, bx, by, bw, bh, drain);
   endtask

   // -------------------------------------------------------------------------
   // Driver: presents queued items at the falling edge. An item stays on the
   // ports until a rising edge has seen start high with busy low; after that
   // the driver waits out the item's pause before offering the next one. An
   // item flagged for draining is held back until every predicted piece has
   // been received.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // Still waiting for the block to take the current item.
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         start    <= 1'b0;
      end else if (rect_jobs.size() != 0 &&
                   !(rect_jobs[0].drain && pieces_due.size() != 0)) begin
         req_a_x  <= rect_jobs[0].a_x;
         req_a_y  <= rect_jobs[0].a_y;
         req_a_w  <= rect_jobs[0].a_w;
         req_a_h  <= rect_jobs[0].a_h;
         req_b_x  <= rect_jobs[0].b_x;
         req_b_y  <= rect_jobs[0].b_y;
         req_b_w  <= rect_jobs[0].b_w;
         req_b_h  <= rect_jobs[0].b_h;
         hold_cnt <= rect_jobs[0].gap;
         start    <= 1'b1;
         void'(rect_jobs.pop_front());
      end else begin
         start <= 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: at each rising edge, checks a piece on the response ports
   // against the oldest prediction, then predicts the pieces of any item the
   // block takes at this edge. The piece checked always belongs to an earlier
   // item, since the block registers an item before sending its pieces.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            pieces_seen++;
            if (rsp_piece_kind <= KIND_WHOLE) begin
               kind_count[rsp_piece_kind]++;
            end
            if (pieces_due.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: piece with no item behind it:", $realtime);
                  $display("   x=%0d y=%0d w=%0d h=%0d kind=%0d",
                           rsp_piece_x, rsp_piece_y, rsp_piece_w,
                           rsp_piece_h, rsp_piece_kind);
               end
            end else begin
               if (rsp_piece_x !== pieces_due[0].x ||
                   rsp_piece_y !== pieces_due[0].y ||
                   rsp_piece_w !== pieces_due[0].w ||
                   rsp_piece_h !== pieces_due[0].h ||
                   rsp_piece_kind !== pieces_due[0].kind ||
                   rsp_last_piece !== pieces_due[0].last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: piece mismatch", $realtime);
                     $display("   expected x=%0d y=%0d w=%0d h=%0d kind=%0d last=%0b",
                              $signed(pieces_due[0].x),
                              $signed(pieces_due[0].y), pieces_due[0].w,
                              pieces_due[0].h, pieces_due[0].kind,
                              pieces_due[0].last);
                     $display("   got      x=%0d y=%0d w=%0d h=%0d kind=%0d last=%0b",
                              rsp_piece_x, rsp_piece_y, rsp_piece_w,
                              rsp_piece_h, rsp_piece_kind, rsp_last_piece);
                  end
               end
               void'(pieces_due.pop_front());
            end
         end
         taken <= start && !busy;
         if (start && !busy) begin
            items_taken++;
            subtract_rect(req_a_x, req_a_y, req_a_w, req_a_h,
                          req_b_x, req_b_y, req_b_w, req_b_h);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // Directed items: disjoint, touching on each axis, empty A and B,
      // covered and identical, the four-strip case and each single strip,
      // strip pairs, strips whose origin wraps, and the coordinate extremes.
      add_item(0, 0, 10, 10, 20, 0, 5, 5, 1'b0);
      add_item(0, 0, 10, 10, 10, 0, 5, 10, 1'b0);
      add_item(0, 0, 10, 10, 0, -5, 10, 5, 1'b0);
      add_item(0, 0, 0, 10, -5, -5, 20, 20, 1'b0);
      add_item(3, 4, 0, 0, 0, 0, 10, 10, 1'b0);
      add_item(0, 0, 10, 10, 2, 2, 5, 0, 1'b0);
      add_item(0, 0, 10, 10, -1, -1, 12, 12, 1'b0);
      add_item(5, 5, 10, 10, 5, 5, 10, 10, 1'b0);
      add_item(0, 0, 10, 10, 3, 3, 4, 4, 1'b1);
      add_item(0, 0, 10, 10, -5, -5, 8, 20, 1'b0);
      add_item(0, 0, 10, 10, 6, -5, 8, 20, 1'b0);
      add_item(0, 0, 10, 10, -5, -5, 20, 8, 1'b0);
      add_item(0, 0, 10, 10, -5, 6, 20, 8, 1'b0);
      add_item(0, 0, 10, 10, 3, -5, 4, 20, 1'b0);
      add_item(0, 0, 10, 10, -5, 3, 20, 4, 1'b0);
      add_item(0, 0, 10, 10, 3, 3, 20, 20, 1'b0);
      add_item(32000, 0, 32767, 10, 32760, -5, 100, 20, 1'b0);
      add_item(0, 32000, 10, 32767, -5, 32760, 20, 100, 1'b0);
      add_item(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
      add_item(-32768, -32768, 32767, 32767, -32768, -32768, 1, 1, 1'b0);
      add_item(32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 1'b0);
      add_item(-1, -1, 32767, 32767, -1, -1, 32767, 32767, 1'b0);

      // Random items, in stretches that alternate between mostly back-to-back
      // traffic and random pauses. Two of them wait for the block to drain.
      for (int i = 0; i < 250; i++) begin
         gap_busy = ((i / 40) % 2) == 1;
         add_random_item(i == 100 || i == 200);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_taken != items_total) begin
         @(posedge clock);
      end
      while (pieces_due.size() != 0) begin
         @(posedge clock);
      end
      // A few more cycles to catch any stray piece after the last one.
      repeat (8) @(posedge clock);

      $display("Sent %0d items, %0d of them fully covered; checked %0d pieces",
               items_total, items_covered, pieces_seen);
      $display("Pieces by kind: left %0d, right %0d, top %0d, bottom %0d, whole %0d",
               kind_count[KIND_LEFT], kind_count[KIND_RIGHT], kind_count[KIND_TOP],
               kind_count[KIND_BOTTOM], kind_count[KIND_WHOLE]);
      if (error_count == 0) begin
         $display("rect_subtract_pieces test passed");
      end else begin
         $display("%0d pieces were wrong or unexpected", error_count);
         $display("rect_subtract_pieces test failed");
      end
      $finish;
   end

   // Watchdog: a correct run takes well under a tenth of this.
   initial begin
      #1000000;
      $display("Timed out with %0d of %0d items taken, %0d pieces outstanding",
               items_taken, items_total, pieces_due.size());
      $display("rect_subtract_pieces test failed");
      $finish;
   end

endmodule
